@@ sv/asgr_pkg.sv @@
package asgr_pkg;

   localparam int MaxBytesDefault = 32;
   localparam int QueueDepth      = 2;

   localparam logic [7:0] ChEsc    = 8'h1B;
   localparam logic [7:0] ChOpen   = 8'h5B;
   localparam logic [7:0] ChSemi   = 8'h3B;
   localparam logic [7:0] ChEnd    = 8'h6D;
   localparam logic [7:0] ChDigLo  = 8'h30;
   localparam logic [7:0] ChDigHi  = 8'h39;
   localparam logic [7:0] ColourLo = 8'd30;
   localparam logic [7:0] ColourHi = 8'd37;

   // byte classes as seen by the parser
   typedef enum logic [2:0] {
      CLS_ESC,
      CLS_OPEN,
      CLS_SEMI,
      CLS_END,
      CLS_DIGIT,
      CLS_OTHER
   } asgr_class_type;

   typedef enum logic [1:0] {
      PH_BRACKET,
      PH_DIGIT,
      PH_NUMBER
   } asgr_phase_type;

   typedef struct packed {
      logic           mode;
      asgr_class_type cls;
      logic [3:0]     digit;
   } asgr_item_type;

   typedef struct packed {
      logic       accepted;
      logic       complete;
      logic       abandoned;
      logic       valid_res;
      logic [2:0] attr_code;
      logic       color_present;
      logic [2:0] color_code;
   } asgr_result_type;

   // dense attribute code; bit 3 flags an accepted number
   function automatic logic [3:0] attr_map(input logic [7:0] n);
      logic [3:0] r;
      case (n)
         8'd0:    r = 4'b1_000;
         8'd1:    r = 4'b1_001;
         8'd2:    r = 4'b1_010;
         8'd3:    r = 4'b1_011;
         8'd5:    r = 4'b1_100;
         8'd7:    r = 4'b1_101;
         8'd8:    r = 4'b1_110;
         default: r = 4'b0_000;
      endcase
      return r;
   endfunction

endpackage

@@ sv/asgr_if.sv @@
interface asgr_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] byte_in;

   modport source (output valid, output mode, output byte_in, input ready);
   modport sink   (input valid, input mode, input byte_in, output ready);
endinterface

interface asgr_rsp_if;
   logic       valid;
   logic       ready;
   logic       accepted;
   logic       complete;
   logic       abandoned;
   logic       valid_res;
   logic [2:0] attr_code;
   logic       color_present;
   logic [2:0] color_code;

   modport source (output valid, output accepted, output complete, output abandoned,
                   output valid_res, output attr_code, output color_present,
                   output color_code, input ready);
   modport sink   (input valid, input accepted, input complete, input abandoned,
                   input valid_res, input attr_code, input color_present,
                   input color_code, output ready);
endinterface

@@ sv/ansi_sgr_sequence_parser.sv @@
// sgr escape parser: one result per transaction; each transaction passes through the queue
// and then the back end result register before its result is ready
// throughput one transaction per cycle while the result side does not stall, set by the parse update in the back end
// a two-entry queue and an output register let either side stall on its own; a full queue
// holds the request side until the cycle after the result side resumes
// reset is synchronous, active high: clears the queue, parse state and output valid
// no clearing pass, the block takes transactions in the first cycle after reset
module ansi_sgr_sequence_parser #(
   parameter int MAX_BYTES = asgr_pkg::MaxBytesDefault
) (
   input logic        clock,
   input logic        reset,
   asgr_req_if.sink   req,
   asgr_rsp_if.source rsp
);

   // front to queue
   logic                    push_valid;
   logic                    push_ready;
   asgr_pkg::asgr_item_type push_item;

   // queue to back end
   logic                    pop_valid;
   logic                    pop_ready;
   asgr_pkg::asgr_item_type pop_item;

   // front: byte classification, no state
   asgr_front u_front (
      .req        (req),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   // decouples the request side from the result side
   asgr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   // back end: length limit, end-of-sequence hold, digit accumulators, result register
   asgr_back #(
      .MAX_BYTES (MAX_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item       (pop_item),
      .item_ready (pop_ready),
      .rsp        (rsp)
   );

endmodule

@@ sv/asgr_front.sv @@
module asgr_front (
   asgr_req_if.sink              req,
   output logic                  push_valid,
   output asgr_pkg::asgr_item_type push_item,
   input  logic                  push_ready
);

   asgr_pkg::asgr_class_type cls;

   always_comb begin
      unique case (req.byte_in) inside
         asgr_pkg::ChEsc:                         cls = asgr_pkg::CLS_ESC;
         asgr_pkg::ChOpen:                        cls = asgr_pkg::CLS_OPEN;
         asgr_pkg::ChSemi:                        cls = asgr_pkg::CLS_SEMI;
         asgr_pkg::ChEnd:                         cls = asgr_pkg::CLS_END;
         [asgr_pkg::ChDigLo:asgr_pkg::ChDigHi]:   cls = asgr_pkg::CLS_DIGIT;
         default:                                 cls = asgr_pkg::CLS_OTHER;
      endcase
   end

   assign push_valid      = req.valid;
   assign push_item.mode  = req.mode;
   assign push_item.cls   = cls;
   assign push_item.digit = req.byte_in[3:0];
   assign req.ready       = push_ready;

endmodule

@@ sv/asgr_queue.sv @@
module asgr_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  asgr_pkg::asgr_item_type push_item,
   output logic                    push_ready,
   output logic                    pop_valid,
   output asgr_pkg::asgr_item_type pop_item,
   input  logic                    pop_ready
);

   localparam int PtrW = $clog2(asgr_pkg::QueueDepth);
   localparam int CntW = $clog2(asgr_pkg::QueueDepth + 1);

   asgr_pkg::asgr_item_type entry_ff [asgr_pkg::QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push, pop;

   assign push_ready = (count_ff != CntW'(asgr_pkg::QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointers wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(asgr_pkg::QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(asgr_pkg::QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ sv/asgr_back.sv @@
module asgr_back #(
   parameter int MAX_BYTES = asgr_pkg::MaxBytesDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  asgr_pkg::asgr_item_type item,
   output logic                    item_ready,
   asgr_rsp_if.source              rsp
);

   localparam int LenW = $clog2(MAX_BYTES + 1);

   logic [LenW-1:0]          len_ff, len_in;
   logic                     hold_ff, hold_in;
   asgr_pkg::asgr_phase_type phase_ff, phase_in;
   logic [1:0]               count_ff, count_in;
   logic [7:0]               accum_ff, accum_in;
   logic [7:0]               first_ff, first_in;
   logic [7:0]               second_ff, second_in;
   logic                     err_ff, err_in;
   logic                     out_valid_ff, out_valid_in;
   asgr_pkg::asgr_result_type res_ff, res_in;

   logic        adv;
   logic [11:0] accum_next;
   logic [7:0]  accum_sat;
   logic [7:0]  attr_n, fg_n;
   logic [3:0]  attr_m;
   logic        has_fg, fg_ok, form_ok;

   assign item_ready = !out_valid_ff || rsp.ready;
   assign adv        = item_valid && item_ready;

   // accum * 10 + digit, saturating at 255
   assign accum_next = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0} + {8'h00, item.digit};
   assign accum_sat  = (accum_next > 12'd255) ? 8'hFF : accum_next[7:0];

   // next state
   always_comb begin
      len_in    = len_ff;
      hold_in   = hold_ff;
      phase_in  = phase_ff;
      count_in  = count_ff;
      accum_in  = accum_ff;
      first_in  = first_ff;
      second_in = second_ff;
      err_in    = err_ff;
      if (adv && item.mode) begin
         len_in    = '0;
         hold_in   = 1'b0;
         phase_in  = asgr_pkg::PH_BRACKET;
         count_in  = '0;
         accum_in  = '0;
         first_in  = '0;
         second_in = '0;
         err_in    = 1'b0;
      end else if (adv && !hold_ff) begin
         if (len_ff == '0) begin
            if (item.cls == asgr_pkg::CLS_ESC) begin
               len_in    = LenW'(1);
               phase_in  = asgr_pkg::PH_BRACKET;
               count_in  = '0;
               accum_in  = '0;
               first_in  = '0;
               second_in = '0;
               err_in    = 1'b0;
            end
         end else if (len_ff < LenW'(MAX_BYTES)) begin
            len_in = len_ff + 1'b1;
            if (item.cls == asgr_pkg::CLS_END) begin
               hold_in = 1'b1;
            end else if (!err_ff) begin
               if (phase_ff == asgr_pkg::PH_BRACKET) begin
                  if (item.cls == asgr_pkg::CLS_OPEN) begin
                     phase_in = asgr_pkg::PH_DIGIT;
                  end else begin
                     err_in = 1'b1;
                  end
               end else if (item.cls == asgr_pkg::CLS_DIGIT) begin
                  accum_in = accum_sat;
                  phase_in = asgr_pkg::PH_NUMBER;
               end else if (item.cls == asgr_pkg::CLS_SEMI &&
                            phase_ff == asgr_pkg::PH_NUMBER && count_ff < 2'd2) begin
                  if (count_ff == 2'd0) begin
                     first_in = accum_ff;
                  end else begin
                     second_in = accum_ff;
                  end
                  count_in = count_ff + 1'b1;
                  accum_in = '0;
                  phase_in = asgr_pkg::PH_DIGIT;
               end else begin
                  err_in = 1'b1;
               end
            end
         end else begin
            len_in    = '0;
            hold_in   = 1'b0;
            phase_in  = asgr_pkg::PH_BRACKET;
            count_in  = '0;
            accum_in  = '0;
            first_in  = '0;
            second_in = '0;
            err_in    = 1'b0;
         end
      end
   end

   // completion check
   assign attr_n  = (count_ff == 2'd0) ? accum_ff : first_ff;
   assign has_fg  = (count_ff != 2'd0);
   assign fg_n    = (count_ff == 2'd1) ? accum_ff : second_ff;
   assign attr_m  = asgr_pkg::attr_map(attr_n);
   assign fg_ok   = (fg_n >= asgr_pkg::ColourLo) && (fg_n <= asgr_pkg::ColourHi);
   assign form_ok = !err_ff && (phase_ff == asgr_pkg::PH_NUMBER);

   // result fields
   always_comb begin
      res_in = '0;
      if (!item.mode && !hold_ff) begin
         if (len_ff == '0) begin
            res_in.accepted = (item.cls == asgr_pkg::CLS_ESC);
         end else if (len_ff < LenW'(MAX_BYTES)) begin
            res_in.accepted = 1'b1;
            if (item.cls == asgr_pkg::CLS_END) begin
               res_in.complete = 1'b1;
               if (form_ok && attr_m[3] && (!has_fg || fg_ok)) begin
                  res_in.valid_res     = 1'b1;
                  res_in.attr_code     = attr_m[2:0];
                  res_in.color_present = has_fg;
                  res_in.color_code    = has_fg ? 3'(fg_n - asgr_pkg::ColourLo) : 3'd0;
               end
            end
         end else begin
            res_in.accepted  = 1'b1;
            res_in.abandoned = 1'b1;
         end
      end
   end

   assign out_valid_in = adv ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         hold_ff      <= 1'b0;
         phase_ff     <= asgr_pkg::PH_BRACKET;
         count_ff     <= '0;
         accum_ff     <= '0;
         first_ff     <= '0;
         second_ff    <= '0;
         err_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         hold_ff      <= hold_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         accum_ff     <= accum_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.accepted      = res_ff.accepted;
   assign rsp.complete      = res_ff.complete;
   assign rsp.abandoned     = res_ff.abandoned;
   assign rsp.valid_res     = res_ff.valid_res;
   assign rsp.attr_code     = res_ff.attr_code;
   assign rsp.color_present = res_ff.color_present;
   assign rsp.color_code    = res_ff.color_code;

endmodule
